/* src/bgql_pkg.sv */
// package: types, constants and helpers of the glyph quad layout block
`timescale 1ns / 1ps
package bgql_pkg;

  localparam int unsigned MaxGlyphs = 1024;

  localparam logic [15:0] ScaleRst     = 16'd2458;
  localparam logic [15:0] TexDimRst    = 16'd256;
  localparam logic [7:0]  CharFallback = 8'h3F;
  localparam logic [7:0]  CharNewline  = 8'h0A;
  localparam logic [7:0]  CharNull     = 8'h00;
  localparam logic [16:0] TexOne       = 17'h10000;
  localparam logic [2:0]  LastMulStep  = 3'd4;
  localparam logic [1:0]  LastDivStep  = 2'd3;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_CHAR  = 2'd1,
    MODE_START = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    REG_SCALE    = 3'd0,
    REG_LINE_H   = 3'd1,
    REG_TEX_W    = 3'd2,
    REG_TEX_H    = 3'd3,
    REG_ORIGIN_X = 3'd4,
    REG_ORIGIN_Y = 3'd5,
    REG_COUNT    = 3'd6
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NL_MUL,
    ST_NL_ADD,
    ST_SRCH,
    ST_CMP,
    ST_MUL,
    ST_ACC,
    ST_DIV_GO,
    ST_DIV,
    ST_EMIT
  } state_e;

  typedef struct packed {
    mode_e              mode;
    logic [9:0]         entry_index;
    logic [15:0]        glyph_id;
    logic [15:0]        atlas_x;
    logic [15:0]        atlas_y;
    logic [15:0]        glyph_width;
    logic [15:0]        glyph_height;
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic signed [15:0] advance_x;
    logic [7:0]         char_code;
  } in_t;

  typedef struct packed {
    logic               status;
    logic signed [23:0] screen_left;
    logic signed [23:0] screen_top;
    logic signed [23:0] screen_right;
    logic signed [23:0] screen_bottom;
    logic [16:0]        tex_left;
    logic [16:0]        tex_top;
    logic [16:0]        tex_right;
    logic [16:0]        tex_bottom;
  } out_t;

  function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
    logic signed [23:0] r;
    if (v > 28'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -28'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

/* src/bgql_ram.sv */
// generic single-port ram with registered read
`timescale 1ns / 1ps
module bgql_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

/* src/bgql_div.sv */
// radix-2 texture coordinate divider, one quotient bit per cycle
`timescale 1ns / 1ps
module bgql_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [16:0] pix_i,
  input  logic [15:0] div_i,
  output logic        done_o,
  output logic [16:0] quo_o
);
  import bgql_pkg::*;

  logic        busy_q;
  logic        done_q;
  logic [4:0]  cnt_q;
  logic [15:0] rem_q;
  logic [16:0] quo_q;
  logic [16:0] rem2;
  logic        ge;

  assign rem2 = {rem_q, 1'b0};
  assign ge   = rem2 >= {1'b0, div_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (start_i) begin
        // pix >= div means the quotient reaches one, which saturates
        if (div_i == 16'd0 || pix_i >= {1'b0, div_i}) begin
          done_q <= 1'b1;
        end else begin
          done_q <= 1'b0;
          busy_q <= 1'b1;
          cnt_q  <= 5'd16;
        end
      end else if (busy_q) begin
        cnt_q  <= cnt_q - 5'd1;
        done_q <= cnt_q == 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
        end
      end else begin
        done_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= pix_i[15:0];
      quo_q <= (div_i == 16'd0 || pix_i >= {1'b0, div_i}) ? TexOne : 17'd0;
    end else if (busy_q) begin
      rem_q <= ge ? 16'(rem2 - {1'b0, div_i}) : rem2[15:0];
      quo_q <= {quo_q[15:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

/* src/bitmap_glyph_quad_layout_top.sv */
// top level: glyph table, binary search, shared multiplier and quad layout
`timescale 1ns / 1ps
// Loads, start-string and clear items are done in the idle state. A newline passes
// through a multiply state and an add state. A character probes the glyph table by
// binary search, each probe a registered ram read and then a compare, and the search
// runs again for the '?' fallback when an ASCII code misses. A hit then uses the one
// 18x17 multiplier for five scaled terms (multiply, then accumulate) and the radix-2
// divider for four texture coordinates, then an emit state hands over the result.
// No item is taken until the current one is done; a finished result waits in the
// output register while the next item is accepted.
module bitmap_glyph_quad_layout_top #(
  parameter int unsigned MAX_GLYPHS = bgql_pkg::MaxGlyphs
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [4:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  bgql_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output bgql_pkg::out_t out_data_o
);
  import bgql_pkg::*;

  localparam int unsigned AW = $clog2(MAX_GLYPHS);
  localparam int unsigned CW = $clog2(MAX_GLYPHS + 1);

  // configuration
  logic [15:0]        scale_q, line_h_q, tex_w_q, tex_h_q;
  logic signed [23:0] org_x_q, org_y_q;
  logic [10:0]        count_q;
  logic               cfg_wr;
  reg_e               cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= ScaleRst;
      line_h_q <= '0;
      tex_w_q  <= TexDimRst;
      tex_h_q  <= TexDimRst;
      org_x_q  <= '0;
      org_y_q  <= '0;
      count_q  <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SCALE:    scale_q  <= pwdata[15:0];
        REG_LINE_H:   line_h_q <= pwdata[15:0];
        REG_TEX_W:    tex_w_q  <= pwdata[15:0];
        REG_TEX_H:    tex_h_q  <= pwdata[15:0];
        REG_ORIGIN_X: org_x_q  <= pwdata[23:0];
        REG_ORIGIN_Y: org_y_q  <= pwdata[23:0];
        REG_COUNT:    count_q  <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SCALE:    prdata = {16'd0, scale_q};
      REG_LINE_H:   prdata = {16'd0, line_h_q};
      REG_TEX_W:    prdata = {16'd0, tex_w_q};
      REG_TEX_H:    prdata = {16'd0, tex_h_q};
      REG_ORIGIN_X: prdata = {8'd0, org_x_q};
      REG_ORIGIN_Y: prdata = {8'd0, org_y_q};
      REG_COUNT:    prdata = {21'd0, count_q};
      default:      prdata = '0;
    endcase
  end

  // sequencer and datapath registers
  state_e             state_q, state_d;
  logic               in_acc, load_ok, out_free, retry_q, hit, div_done;
  logic [31:0]        slot32, count32;
  logic [CW-1:0]      cnt_eff, lo_q, end_q, mid_q, mid_d;
  logic [AW-1:0]      ram_addr;
  logic [7:0]         key_q;
  logic [15:0]        id_rd;
  logic [63:0]        box_rd;
  logic [47:0]        met_rd;
  logic [15:0]        bx_x_q, bx_y_q, bx_w_q, bx_h_q;
  logic signed [15:0] mt_ox_q, mt_oy_q, mt_adv_q;
  logic [2:0]         step_q;
  logic signed [17:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [34:0] prod_q;
  logic signed [27:0] term, base;
  logic signed [23:0] pen_q, line_q, acc_sat;
  logic [23:0]        nl_step;
  logic [15:0]        pix_a, pix_len, div_by;
  logic [16:0]        pix, quo;
  out_t               res_q, out_q;
  logic               out_valid_q;

  assign in_stall_o = state_q != ST_IDLE;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign slot32     = 32'(in_data_i.entry_index);
  assign load_ok    = in_acc && in_data_i.mode == MODE_LOAD && slot32 < 32'(MAX_GLYPHS);
  assign count32    = 32'(count_q);
  assign cnt_eff    = (count32 > 32'(MAX_GLYPHS)) ? CW'(MAX_GLYPHS) : CW'(count32);
  assign mid_d      = CW'(lo_q + ((end_q - lo_q - CW'(1)) >> 1));
  assign ram_addr   = load_ok ? slot32[AW-1:0] : mid_d[AW-1:0];
  assign hit        = id_rd == {8'd0, key_q};
  assign out_free   = ~out_valid_q | ~out_stall_i;

  bgql_ram #(.WIDTH(16), .DEPTH(MAX_GLYPHS)) u_id_ram (
    .clk_i, .we_i(load_ok), .addr_i(ram_addr), .wdata_i(in_data_i.glyph_id), .rdata_o(id_rd)
  );

  bgql_ram #(.WIDTH(64), .DEPTH(MAX_GLYPHS)) u_box_ram (
    .clk_i, .we_i(load_ok), .addr_i(ram_addr),
    .wdata_i({in_data_i.atlas_x, in_data_i.atlas_y, in_data_i.glyph_width,
              in_data_i.glyph_height}),
    .rdata_o(box_rd)
  );

  bgql_ram #(.WIDTH(48), .DEPTH(MAX_GLYPHS)) u_met_ram (
    .clk_i, .we_i(load_ok), .addr_i(ram_addr),
    .wdata_i({in_data_i.offset_x, in_data_i.offset_y, in_data_i.advance_x}),
    .rdata_o(met_rd)
  );

  // shared multiplier operands: the five scaled terms, or the line step
  always_comb begin
    mul_b = $signed({1'b0, scale_q});
    if (state_q == ST_NL_MUL) begin
      mul_a = $signed({2'b00, line_h_q});
    end else begin
      case (step_q)
        3'd0:    mul_a = 18'(mt_ox_q);
        3'd1:    mul_a = $signed({2'b00, bx_w_q}) + 18'(mt_ox_q);
        3'd2:    mul_a = 18'(mt_oy_q);
        3'd3:    mul_a = $signed({2'b00, bx_h_q}) + 18'(mt_oy_q);
        default: mul_a = 18'(mt_adv_q);
      endcase
    end
  end

  // floor division by 256 is an arithmetic shift
  assign term = 28'(prod_q >>> 8);

  always_comb begin
    if (step_q < 3'd2) begin
      base = 28'(org_x_q) + 28'(pen_q);
    end else if (step_q < LastMulStep) begin
      base = 28'(org_y_q) + 28'(line_q);
    end else begin
      base = 28'(pen_q);
    end
  end

  assign acc_sat = sat24(base + term);
  assign nl_step = {prod_q[31:12], 4'b0000};

  // texture divisions: left, top, right, bottom
  assign pix_a   = step_q[0] ? bx_y_q : bx_x_q;
  assign pix_len = step_q[0] ? bx_h_q : bx_w_q;
  assign div_by  = step_q[0] ? tex_h_q : tex_w_q;
  assign pix     = step_q[1] ? {1'b0, pix_a} + {1'b0, pix_len} : {1'b0, pix_a};

  bgql_div u_div (
    .clk_i, .rst_ni, .start_i(state_q == ST_DIV_GO), .pix_i(pix), .div_i(div_by),
    .done_o(div_done), .quo_o(quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && in_data_i.mode == MODE_CHAR && in_data_i.char_code != CharNull) begin
          state_d = (in_data_i.char_code == CharNewline) ? ST_NL_MUL : ST_SRCH;
        end
      end
      ST_NL_MUL: state_d = ST_NL_ADD;
      ST_NL_ADD: state_d = ST_IDLE;
      ST_SRCH: begin
        if (lo_q < end_q) begin
          state_d = ST_CMP;
        end else if (!retry_q) begin
          state_d = ST_EMIT;
        end
      end
      ST_CMP: state_d = hit ? ST_MUL : ST_SRCH;
      ST_MUL: state_d = ST_ACC;
      ST_ACC: state_d = (step_q == LastMulStep) ? ST_DIV_GO : ST_MUL;
      ST_DIV_GO: state_d = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_d = (step_q[1:0] == LastDivStep) ? ST_EMIT : ST_DIV_GO;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers and pen position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_q     <= 1'b0;
      step_q      <= '0;
      pen_q       <= '0;
      line_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          step_q <= '0;
          if (in_acc) begin
            case (in_data_i.mode)
              MODE_CHAR: begin
                retry_q <= ~in_data_i.char_code[7];
                if (in_data_i.char_code == CharNewline) begin
                  pen_q <= '0;
                end
              end
              MODE_START: pen_q <= '0;
              MODE_CLEAR: begin
                pen_q  <= '0;
                line_q <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_NL_ADD: line_q <= sat24(28'(line_q) + $signed({4'b0000, nl_step}));
        ST_SRCH: begin
          if (lo_q >= end_q) begin
            retry_q <= 1'b0;
          end
        end
        ST_ACC: begin
          if (step_q == LastMulStep) begin
            pen_q  <= acc_sat;
            step_q <= '0;
          end else begin
            step_q <= step_q + 3'd1;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            step_q <= step_q + 3'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // search bounds, glyph fields and result
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        key_q <= in_data_i.char_code[7] ? CharFallback : in_data_i.char_code;
        lo_q  <= '0;
        end_q <= cnt_eff;
      end
      ST_NL_MUL: prod_q <= mul_a * mul_b;
      ST_SRCH: begin
        if (lo_q < end_q) begin
          mid_q <= mid_d;
        end else if (retry_q) begin
          key_q <= CharFallback;
          lo_q  <= '0;
          end_q <= cnt_eff;
        end else begin
          // missing glyph: status set, every other field zero
          res_q <= out_t'({1'b1, {($bits(out_t) - 1){1'b0}}});
        end
      end
      ST_CMP: begin
        if (hit) begin
          {bx_x_q, bx_y_q, bx_w_q, bx_h_q} <= box_rd;
          {mt_ox_q, mt_oy_q, mt_adv_q}     <= met_rd;
          res_q.status                     <= 1'b0;
        end else if (id_rd > {8'd0, key_q}) begin
          end_q <= mid_q;
        end else begin
          lo_q <= mid_q + CW'(1);
        end
      end
      ST_MUL: prod_q <= mul_a * mul_b;
      ST_ACC: begin
        case (step_q)
          3'd0:    res_q.screen_left   <= acc_sat;
          3'd1:    res_q.screen_right  <= acc_sat;
          3'd2:    res_q.screen_top    <= acc_sat;
          3'd3:    res_q.screen_bottom <= acc_sat;
          default: ;
        endcase
      end
      ST_DIV: begin
        if (div_done) begin
          case (step_q[1:0])
            2'd0:    res_q.tex_left   <= quo;
            2'd1:    res_q.tex_top    <= quo;
            2'd2:    res_q.tex_right  <= quo;
            default: res_q.tex_bottom <= quo;
          endcase
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_q <= res_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_probe_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CMP |-> (mid_q >= lo_q && mid_q < end_q && end_q <= cnt_eff))
    else $error("search probe outside bounds");

  a_missing_is_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status |-> (out_data_o.screen_left == 24'sd0 &&
      out_data_o.screen_bottom == 24'sd0 && out_data_o.tex_left == 17'd0 &&
      out_data_o.tex_bottom == 17'd0))
    else $error("missing glyph result carries data");

  a_tex_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.tex_left <= TexOne && out_data_o.tex_top <= TexOne &&
      out_data_o.tex_right <= TexOne && out_data_o.tex_bottom <= TexOne))
    else $error("texture coordinate above one");

  a_div_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside division step");
`endif

endmodule

/* tb/sv/tb_bitmap_glyph_quad_layout_top.sv */
// testbench for the glyph quad layout block: directed and random text with a built-in predictor
`timescale 1ns / 1ps
module tb_bitmap_glyph_quad_layout_top;
  import bgql_pkg::*;

  localparam int TableDepth   = 1024;
  localparam int SettleCycles = 400;
  localparam int IdleLimit    = 6000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_t         in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b1;
  out_t        out_data_o;

  bitmap_glyph_quad_layout_top dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // glyph table and pen state as the block should hold them
  logic [15:0]        tbl_id   [TableDepth];
  logic [15:0]        tbl_ax   [TableDepth];
  logic [15:0]        tbl_ay   [TableDepth];
  logic [15:0]        tbl_w    [TableDepth];
  logic [15:0]        tbl_h    [TableDepth];
  logic signed [15:0] tbl_ox   [TableDepth];
  logic signed [15:0] tbl_oy   [TableDepth];
  logic signed [15:0] tbl_adv  [TableDepth];
  longint pen_x, line_y;
  longint cfg_scale, cfg_line_h, cfg_tex_w, cfg_tex_h, cfg_org_x, cfg_org_y, cfg_count;

  out_t quad_q[$];
  int   fail_count = 0;
  int   idle_cycles = 0;
  int   out_hold = 0;
  int   out_wait = 0;
  bit   quiet = 1'b0;

  function automatic logic signed [23:0] clamp_q4(longint v);
    if (v > 64'sd8388607) return 24'sh7FFFFF;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  function automatic logic [16:0] tex_coord(longint pix, longint div);
    longint q;
    if (div == 0) return TexOne;
    q = (pix << 16) / div;
    return (q > 65536) ? TexOne : q[16:0];
  endfunction

  function automatic int glyph_search(int key);
    int lo, hi, mid;
    lo = 0;
    hi = ((cfg_count > TableDepth) ? TableDepth : int'(cfg_count)) - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (int'(tbl_id[mid]) > key) hi = mid - 1;
      else if (int'(tbl_id[mid]) < key) lo = mid + 1;
      else return mid;
    end
    return -1;
  endfunction

  // layout of one accepted item; a result goes to the quad queue
  function automatic void layout_item(in_t it);
    int     k;
    longint px, py, ox, oy;
    out_t   q;
    k = -1;
    q = '0;
    case (it.mode)
      MODE_LOAD: begin
        tbl_id[it.entry_index]  = it.glyph_id;
        tbl_ax[it.entry_index]  = it.atlas_x;
        tbl_ay[it.entry_index]  = it.atlas_y;
        tbl_w[it.entry_index]   = it.glyph_width;
        tbl_h[it.entry_index]   = it.glyph_height;
        tbl_ox[it.entry_index]  = it.offset_x;
        tbl_oy[it.entry_index]  = it.offset_y;
        tbl_adv[it.entry_index] = it.advance_x;
      end
      MODE_START: pen_x = 0;
      MODE_CLEAR: begin
        pen_x = 0;
        line_y = 0;
      end
      default: begin
        if (it.char_code == CharNewline) begin
          pen_x = 0;
          line_y = longint'(clamp_q4(line_y + ((cfg_line_h * cfg_scale) >> 12) * 16));
        end else if (it.char_code != CharNull) begin
          if (it.char_code < 8'd128) k = glyph_search(int'(it.char_code));
          if (k < 0) k = glyph_search(int'(CharFallback));
          if (k < 0) begin
            q.status = 1'b1;
          end else begin
            px = cfg_org_x + pen_x;
            py = cfg_org_y + line_y;
            ox = longint'(tbl_ox[k]);
            oy = longint'(tbl_oy[k]);
            q.screen_left   = clamp_q4(px + ((ox * cfg_scale) >>> 8));
            q.screen_top    = clamp_q4(py + ((oy * cfg_scale) >>> 8));
            q.screen_right  = clamp_q4(px + (((longint'(tbl_w[k]) + ox) * cfg_scale) >>> 8));
            q.screen_bottom = clamp_q4(py + (((longint'(tbl_h[k]) + oy) * cfg_scale) >>> 8));
            q.tex_left      = tex_coord(longint'(tbl_ax[k]), cfg_tex_w);
            q.tex_top       = tex_coord(longint'(tbl_ay[k]), cfg_tex_h);
            q.tex_right     = tex_coord(longint'(tbl_ax[k]) + longint'(tbl_w[k]), cfg_tex_w);
            q.tex_bottom    = tex_coord(longint'(tbl_ay[k]) + longint'(tbl_h[k]), cfg_tex_h);
            pen_x = longint'(clamp_q4(pen_x + ((longint'(tbl_adv[k]) * cfg_scale) >>> 8)));
          end
          quad_q.push_back(q);
        end
      end
    endcase
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // result checker and watchdog
  always @(posedge clk_i) begin
    out_t e;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (out_valid_o && !out_stall_i) begin
        out_wait = quiet ? 0 : int'($urandom_range(0, 12));
        if (quad_q.size() == 0) begin
          $error("result with no expectation waiting");
          fail_count++;
        end else begin
          e = quad_q.pop_front();
          check_field("status", longint'(e.status), longint'(out_data_o.status));
          check_field("screen_left", longint'(e.screen_left), longint'(out_data_o.screen_left));
          check_field("screen_top", longint'(e.screen_top), longint'(out_data_o.screen_top));
          check_field("screen_right", longint'(e.screen_right),
                      longint'(out_data_o.screen_right));
          check_field("screen_bottom", longint'(e.screen_bottom),
                      longint'(out_data_o.screen_bottom));
          check_field("tex_left", longint'(e.tex_left), longint'(out_data_o.tex_left));
          check_field("tex_top", longint'(e.tex_top), longint'(out_data_o.tex_top));
          check_field("tex_right", longint'(e.tex_right), longint'(out_data_o.tex_right));
          check_field("tex_bottom", longint'(e.tex_bottom), longint'(out_data_o.tex_bottom));
        end
      end
      if (idle_cycles >= IdleLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // receiver stall: per-result wait plus the long hold-off
  initial begin
    forever begin
      @(negedge clk_i);
      if (out_hold > 0) begin
        out_hold--;
        out_stall_i <= 1'b1;
      end else if (out_wait > 0) begin
        out_wait--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_item(in_t it);
    int gap;
    gap = quiet ? 0 : int'($urandom_range(0, 12));
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_data_i  <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    layout_item(it);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (quad_q.size() == 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_SCALE:    cfg_scale  = longint'(value[15:0]);
      REG_LINE_H:   cfg_line_h = longint'(value[15:0]);
      REG_TEX_W:    cfg_tex_w  = longint'(value[15:0]);
      REG_TEX_H:    cfg_tex_h  = longint'(value[15:0]);
      REG_ORIGIN_X: cfg_org_x  = longint'(signed'(value[23:0]));
      REG_ORIGIN_Y: cfg_org_y  = longint'(signed'(value[23:0]));
      REG_COUNT:    cfg_count  = longint'(value[10:0]);
      default: ;
    endcase
  endtask

  task automatic set_layout(int scale, int lh, int tw, int th, int ox, int oy);
    write_reg(REG_SCALE, scale);
    write_reg(REG_LINE_H, lh);
    write_reg(REG_TEX_W, tw);
    write_reg(REG_TEX_H, th);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
  endtask

  function automatic logic [15:0] rnd_pix();
    return ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 255));
  endfunction

  function automatic logic [15:0] rnd_metric();
    return ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'(int'($urandom_range(0, 80)) - 40);
  endfunction

  function automatic in_t glyph_load(int slot, int id);
    in_t it;
    it = '0;
    it.mode = MODE_LOAD;
    it.entry_index = 10'(slot);
    it.glyph_id = 16'(id);
    it.atlas_x = rnd_pix();
    it.atlas_y = rnd_pix();
    it.glyph_width = rnd_pix();
    it.glyph_height = rnd_pix();
    it.offset_x = rnd_metric();
    it.offset_y = rnd_metric();
    it.advance_x = rnd_metric();
    it.char_code = 8'($urandom);
    return it;
  endfunction

  function automatic in_t text_item(mode_e m, int c);
    in_t it;
    it = in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    it.mode = m;
    it.char_code = 8'(c);
    return it;
  endfunction

  task automatic test_missing_glyph();
    // empty table: every character is missing, control codes still act
    set_layout(ScaleRst, 40, 256, 256, 0, 0);
    write_reg(REG_COUNT, 0);
    send_item(text_item(MODE_CHAR, "A"));
    send_item(text_item(MODE_CHAR, 200));
    send_item(text_item(MODE_CHAR, CharNewline));
    send_item(text_item(MODE_CHAR, CharNull));
    send_item(text_item(MODE_START, 0));
    send_item(text_item(MODE_CLEAR, 0));
    drain_results();
  endtask

  task automatic test_directed();
    in_t it;
    // slots 0..3 lack the fallback, slots 0..5 have it
    send_item(glyph_load(0, 0));
    send_item(glyph_load(1, "A"));
    send_item(glyph_load(2, "B"));
    send_item(glyph_load(3, 127));
    send_item(glyph_load(4, CharFallback + 0));
    it = glyph_load(5, 16'hFFFF);
    it.atlas_x = 16'hFFFF; it.atlas_y = 16'hFFFF;
    it.glyph_width = 16'hFFFF; it.glyph_height = 16'hFFFF;
    it.offset_x = 16'sh7FFF; it.offset_y = -16'sh8000; it.advance_x = 16'sh7FFF;
    send_item(it);
    it = glyph_load(1023, "B");
    it.offset_x = -16'sh8000; it.offset_y = 16'sh7FFF; it.advance_x = -16'sh8000;
    send_item(it);
    drain_results();
    write_reg(REG_COUNT, 4);
    send_item(text_item(MODE_CHAR, "A"));
    send_item(text_item(MODE_CHAR, "z"));
    send_item(text_item(MODE_CHAR, 127));
    drain_results();
    write_reg(REG_COUNT, 6);
    // vertical divisor of zero saturates the vertical coordinates
    set_layout(16'hFFFF, 16'hFFFF, 1, 0, 24'h7FFFF0, 24'h800000);
    send_item(text_item(MODE_CHAR, "B"));
    send_item(text_item(MODE_CHAR, "z"));
    send_item(text_item(MODE_CHAR, 255));
    send_item(text_item(MODE_CHAR, 128));
    send_item(text_item(MODE_CHAR, CharNewline));
    send_item(text_item(MODE_CHAR, "A"));
    send_item(text_item(MODE_START, 0));
    send_item(text_item(MODE_CHAR, 127));
    send_item(text_item(MODE_CLEAR, 0));
    send_item(text_item(MODE_CHAR, CharNull));
    drain_results();
  endtask

  task automatic test_full_table();
    // character keys over the whole table only probe the low slots and the
    // midpoints below, so those slots get ascending ids across the id range
    int probe_slots[4];
    probe_slots = '{63, 127, 255, 511};
    quiet = 1'b1;
    for (int i = 0; i < 32; i++) begin
      send_item(glyph_load(i, i * 64 + int'($urandom_range(0, 63))));
    end
    foreach (probe_slots[j]) begin
      send_item(glyph_load(probe_slots[j], probe_slots[j] * 64 + int'($urandom_range(0, 63))));
    end
    quiet = 1'b0;
    drain_results();
    set_layout(0, 0, 65535, 65535, 24'h800000, 24'h7FFFFF);
    write_reg(REG_COUNT, TableDepth);
    for (int i = 0; i < 20; i++) send_item(text_item(MODE_CHAR, int'($urandom_range(0, 255))));
    drain_results();
    write_reg(REG_COUNT, 1500);
    for (int i = 0; i < 10; i++) send_item(text_item(MODE_CHAR, int'($urandom_range(0, 127))));
    drain_results();
  endtask

  task automatic test_random_text(int phase);
    int n, c, r;
    int ids[$];
    n = $urandom_range(1, 40);
    ids.delete();
    for (int i = 0; i < n; i++) ids.push_back($urandom_range(1, 127));
    ids.sort();
    quiet = (phase == 2);
    for (int i = 0; i < n; i++) send_item(glyph_load(i, ids[i]));
    drain_results();
    if (phase % 3 == 0) set_layout($urandom, $urandom, $urandom_range(1, 65535),
                                   $urandom_range(1, 65535), $urandom, $urandom);
    else set_layout($urandom_range(1024, 8192), $urandom_range(0, 64),
                    $urandom_range(64, 512), $urandom_range(64, 512),
                    $urandom_range(0, 4096), $urandom_range(0, 4096));
    write_reg(REG_COUNT, n);
    for (int i = 0; i < 85; i++) begin
      r = $urandom_range(0, 99);
      if (r < 60) c = ids[$urandom_range(0, n - 1)];
      else c = $urandom_range(0, 255);
      if (r < 85) send_item(text_item(MODE_CHAR, c));
      else if (r < 89) send_item(text_item(MODE_CHAR, CharNewline));
      else if (r < 93) send_item(text_item(MODE_START, 0));
      else if (r < 95) send_item(text_item(MODE_CLEAR, 0));
      else send_item(glyph_load($urandom_range(0, TableDepth - 1), $urandom));
    end
    quiet = 1'b0;
    drain_results();
  endtask

  task automatic test_backpressure();
    // receiver holds off while the sender keeps offering characters
    out_hold = 500;
    quiet = 1'b1;
    for (int i = 0; i < 20; i++) send_item(text_item(MODE_CHAR, $urandom_range(1, 127)));
    quiet = 1'b0;
    drain_results();
  endtask

  initial begin
    pen_x = 0; line_y = 0;
    cfg_scale = ScaleRst; cfg_line_h = 0; cfg_tex_w = TexDimRst; cfg_tex_h = TexDimRst;
    cfg_org_x = 0; cfg_org_y = 0; cfg_count = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    test_missing_glyph();
    test_directed();
    test_full_table();
    for (int p = 0; p < 6; p++) test_random_text(p);
    test_backpressure();
    test_random_text(6);
    if (fail_count == 0 && quad_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      if (quad_q.size() != 0) $error("%0d expected results never arrived", quad_q.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
